// ----- hdl/ftsd_pkg.sv -----
// Package for float_to_scaled_decimal_core: constants, state type and the fmul10 times-ten function.
// No dependencies.
`timescale 1ns / 1ps
package ftsd_pkg;
  localparam int unsigned DEF_MAX_SCALE = 8;
  localparam int unsigned MANT_W = 96;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ROUND, ST_STRIP, ST_OUT
  } state_t;

  // float times ten, round to nearest even; input is positive finite nonzero
  function automatic logic [30:0] fmul10(input logic [30:0] a);
    logic [7:0] e;
    logic [23:0] m;
    logic [27:0] p;
    logic [47:0] sh;
    logic [8:0] en;
    logic [4:0] k;
    logic g, st, r;
    logic [24:0] mr;
    e = a[30:23];
    m = (e == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    p = {m, 3'b000} + {2'b00, m, 1'b0};
    // value = p * 2^(max(e,1)-150)
    if (e == 8'd0) begin
      // subnormal: find msb position of p
      k = 5'd0;
      for (int i = 0; i < 28; i++) if (p[i]) k = 5'(i);
      // exact: stays subnormal, or bit 23 lands in the exponent lsb
      if (k < 5'd24) return {7'd0, p[23:0]};
      sh = {20'd0, p} << (5'd27 - k);
      en = 9'(k) - 9'd22;
    end else begin
      k = p[27] ? 5'd27 : (p[26] ? 5'd26 : 5'd25);
      sh = {20'd0, p} << (5'd27 - k);
      en = {1'b0, e} + 9'(k) - 9'd23;
    end
    // sh[27] is msb; mantissa sh[27:4], guard sh[3], sticky sh[2:0]
    g = sh[3];
    st = |sh[2:0];
    r = g & (st | sh[4]);
    mr = {1'b0, sh[27:4]} + 25'(r);
    if (mr[24]) begin
      mr = mr >> 1;
      en = en + 9'd1;
    end
    if (en >= 9'd255) return {8'hFF, 23'd0};
    return {en[7:0], mr[22:0]};
  endfunction
endpackage

// ----- hdl/ftsd_div10.sv -----
// Shared divide-by-ten unit for trailing zero stripping.
// No dependencies.
`timescale 1ns / 1ps
module ftsd_div10 (
  input  logic [31:0] num,
  output logic [31:0] quo,
  output logic        rem_zero
);
  logic [65:0] prod;
  assign prod = {34'd0, num} * 66'h0CCCCCCCD;
  assign quo = prod[66-1:35] >> 0 == 0 ? 32'd0 : 32'(prod[65:35]);
  assign rem_zero = ({quo, 3'b000} + {2'b00, quo, 1'b0}) == {3'b000, num};
endmodule

// ----- hdl/float_to_scaled_decimal_core.sv -----
// Top level of float to scaled decimal conversion.
// Depends on ftsd_pkg and ftsd_div10.
//
// One input item on s_axis (tdata = float_bits), one result item on m_axis.
// The float is scaled by ten in single precision, one step a cycle, at most
// MAX_SCALE steps, then rounded and stripped of trailing decimal zeros one
// digit a cycle through a shared divide-by-ten unit.
// Infinity, NaN and zero skip rounding and stripping and go straight to the
// output; other values pass the scale, round and strip steps in that order.
// One item at a time, s_axis_tready is high only when idle; the next item is
// taken the cycle after the result is accepted.
// The result waits in its output register while m_axis_tready is low.
// Reset (rst, synchronous) empties the block and drops any item in flight.
`timescale 1ns / 1ps
module float_to_scaled_decimal_core #(
  parameter int unsigned MAX_SCALE = ftsd_pkg::DEF_MAX_SCALE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // float_bits
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, is_negative, scale[3:0], mantissa_low[63:0], mantissa_high[31:0], pad
  output logic [103:0] m_axis_tdata
);
  import ftsd_pkg::*;

  state_t state, state_next;
  logic [30:0] v;
  logic neg, status;
  logic [4:0] sc;
  logic [63:0] lo;
  logic [31:0] hi;
  logic [31:0] quo;
  logic rem_zero;

  ftsd_div10 u_div (.num(lo[31:0]), .quo(quo), .rem_zero(rem_zero));

  logic [7:0] ex;
  logic [23:0] mm;
  logic [7:0] sh;
  logic [119:0] big;
  logic [23:0] ip;
  logic [23:0] fr;
  assign ex = v[30:23];
  assign mm = {1'b1, v[22:0]};
  assign sh = ex - 8'd150;
  assign big = {96'd0, mm} << sh[6:0];
  // v below 2^23: integer part and fraction from exponent
  assign ip = (ex < 8'd127) ? 24'd0 : 24'(mm >> (8'd150 - ex));
  assign fr = (ex < 8'd126) ? 24'd0 : 24'(mm << (ex - 8'd126));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_MUL;
      ST_MUL:   if (status || v == 31'd0) state_next = ST_OUT;
                else if (sc >= 5'(MAX_SCALE) || v[30:23] >= 8'd148) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_STRIP;
      ST_STRIP: if (sc == 5'd0 || hi != 32'd0 || !rem_zero || lo[63:32] != 32'd0)
                  state_next = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        v <= s_axis_tdata[30:0];
        neg <= s_axis_tdata[31];
        sc <= '0;
        lo <= '0;
        hi <= '0;
        status <= (s_axis_tdata[30:23] == 8'hFF);
        if (s_axis_tdata[30:0] == 31'd0) begin
          neg <= 1'b0;
          v <= '0;
        end
      end
      ST_MUL: if (status) begin
        neg <= 1'b0;
      end else if (v == 31'd0) begin
        sc <= '0;
        neg <= 1'b0;
      end else if (!(sc >= 5'(MAX_SCALE) || v[30:23] >= 8'd148)) begin
        v <= fmul10(v);
        sc <= sc + 5'd1;
      end
      ST_ROUND: begin
        if (ex < 8'd150) begin
          lo <= 64'(ip) + 64'(fr[23]);
          hi <= '0;
        end else if (ex >= 8'd223) begin
          status <= 1'b1;
          neg <= 1'b0;
          sc <= '0;
        end else begin
          lo <= big[63:0];
          hi <= big[95:64];
        end
        if (ex < 8'd150 && ip == 24'd0 && !fr[23]) sc <= '0;
      end
      ST_STRIP: if (!(sc == 5'd0 || hi != 32'd0 || !rem_zero || lo[63:32] != 32'd0)) begin
        lo <= {32'd0, quo};
        sc <= sc - 5'd1;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = status ? {103'd0, 1'b1}
                               : {2'b00, hi, lo, sc[3:0], neg, 1'b0};
endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for float_to_scaled_decimal_core: float words in, scaled decimals out.
// Predicts each result with a bit-exact integer model of the single-precision steps.
// Depends on the core RTL and ftsd_pkg.
`timescale 1ns / 1ps
module tb_top;
  localparam int SCALE_LIMIT = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic        status;
    logic        negative;
    logic [3:0]  scale;
    logic [95:0] mant;
  } decimal_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // float_bits
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status, is_negative, scale[3:0], mantissa_low[63:0], mantissa_high[31:0], pad
  logic [103:0] m_axis_tdata;

  decimal_t pending_decimals[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       stall_left = 0;
  bit       idling_on = 1'b1;

  float_to_scaled_decimal_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [30:0] times_ten(input logic [30:0] a);
    int          en, k, s;
    logic [23:0] sig;
    logic [27:0] p, q, rem, half;
    logic [24:0] r;
    en = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    sig = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    p = {4'd0, sig} * 28'd10;
    k = 0;
    for (int i = 0; i < 28; i++) if (p[i]) k = i;
    if (en + k - 23 < 1) return {8'd0, p[22:0]};
    if (k <= 23) begin
      r = 25'(p << (23 - k));
    end else begin
      s = k - 23;
      q = p >> s;
      rem = p & ((28'd1 << s) - 28'd1);
      half = 28'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 28'd1;
      r = q[24:0];
    end
    en = en + k - 23;
    if (r[24]) begin
      r = r >> 1;
      en = en + 1;
    end
    if (en >= 255) return {8'hFF, 23'd0};
    return {8'(en), r[22:0]};
  endfunction

  function automatic decimal_t to_decimal(input logic [31:0] fb);
    decimal_t    d;
    logic [30:0] v;
    logic [23:0] sig;
    logic [95:0] m;
    logic [23:0] n, rem;
    int          sc, e, s;
    d = '0;
    v = fb[30:0];
    if (v[30:23] == 8'hFF) begin
      d.status = 1'b1;
      return d;
    end
    if (v == 31'd0) return d;
    sc = 0;
    while (sc < SCALE_LIMIT && v[30:23] < 8'd148) begin
      v = times_ten(v);
      sc++;
    end
    e = int'(v[30:23]);
    sig = (e == 0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    if (e < 150) begin
      s = (e == 0) ? 149 : 150 - e;
      if (s >= 25) begin
        m = '0;
      end else begin
        n = sig >> s;
        rem = sig & ((24'd1 << s) - 24'd1);
        if (rem >= (24'd1 << (s - 1))) n = n + 24'd1;
        m = {72'd0, n};
      end
    end else begin
      if (e - 127 >= 96) begin
        d.status = 1'b1;
        return d;
      end
      m = {72'd0, sig} << (e - 150);
    end
    d.negative = fb[31];
    if (m == '0) return d;
    while (sc > 0 && m[95:64] == 32'd0 && (m % 96'd10) == 96'd0) begin
      m = m / 96'd10;
      sc--;
    end
    d.scale = 4'(sc);
    d.mant = m;
    return d;
  endfunction

  task automatic send_float(input logic [31:0] fb);
    pending_decimals.push_back(to_decimal(fb));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= fb;
    @(posedge clk iff s_axis_tready);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    while (pending_decimals.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float(input int e_lo, input int e_hi);
    return {1'($urandom), 8'($urandom_range(e_lo, e_hi)), 23'($urandom)};
  endfunction

  task automatic test_directed;
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
             32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000,
             32'h3F80_0000, 32'hBF00_0000, 32'h3DCC_CCCD, 32'h3EAA_AAAB,
             32'h4B00_0000, 32'h4AFF_FFFF, 32'h6F80_0000, 32'h6F7F_FFFF,
             32'h2F80_0000, 32'h3400_0000, 32'h42C8_0000, 32'h5555_5555,
             32'hAAAA_AAAA};
    foreach (vals[i]) send_float(vals[i]);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: send_float($urandom);
        1: send_float(rand_float(0, 5));
        2: send_float(rand_float(90, 130));
        3: send_float(rand_float(140, 160));
        4: send_float(rand_float(180, 225));
        default: send_float(rand_float(100, 170));
      endcase
    end
  endtask

  task automatic test_paused;
    for (int i = 0; i < 10; i++) begin
      send_float(rand_float(110, 160));
      s_axis_tvalid <= 1'b0;
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst || !idling_on) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= (stall_left == 0);
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decimal_t want, got;
    got = '0;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[0];
      got.negative = m_axis_tdata[1];
      got.scale = m_axis_tdata[5:2];
      got.mant = {m_axis_tdata[101:70], m_axis_tdata[69:6]};
      if (pending_decimals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", m_axis_tdata);
      end else begin
        want = pending_decimals.pop_front();
        if (got.status !== want.status || got.negative !== want.negative ||
            got.scale !== want.scale || got.mant !== want.mant) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st=%b neg=%b sc=%0d m=%h got st=%b neg=%b sc=%0d m=%h",
                     want.status, want.negative, want.scale, want.mant,
                     got.status, got.negative, got.scale, got.mant);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_paused();
    test_random(200);
    idling_on = 1'b0;
    test_random(100);
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_decimals.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
